[rtl/tlfe_pkg.sv]
package tlfe_pkg;

  typedef enum logic [1:0] {
    ACT_RX    = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_SLEEP = 2'd2,
    ACT_CLOSE = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    CFG_RETRY_INTERVAL = 1'd0,
    CFG_REPORT_ENABLE  = 1'd1
  } cfg_index_e;

  localparam logic [7:0]  HDR_TOUCH   = 8'h66;
  localparam logic [7:0]  HDR_CMD     = 8'h80;
  localparam logic [7:0]  HDR_ACK     = 8'h61;
  localparam logic [7:0]  TAIL_CMD    = 8'h65;
  localparam logic [7:0]  TAIL_LF     = 8'h0A;
  localparam logic [7:0]  ACK_MID     = 8'h0D;
  localparam logic [7:0]  SLEEP_MAX   = 8'hF0;
  localparam logic [7:0]  CLOSE_ARG   = 8'hFF;
  localparam logic [15:0] RETRY_RESET = 16'd50;
  localparam logic [15:0] TICKS_MAX   = 16'hFFFF;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_IW  = $clog2(MAX_RES);
  localparam int unsigned RES_CW  = $clog2(MAX_RES + 1);

  localparam logic        KIND_TX     = 1'b0;
  localparam logic        KIND_REPORT = 1'b1;

endpackage

[rtl/touch_link_frame_endpoint.sv]
// Results: the results of a transaction are written to the result buffer when it is
// accepted and then moved one at a time into the single output register, which
// out_stall_i can hold. Throughput: one input transaction per cycle when it yields
// no result and none are pending; a transaction yielding n results (n up to 4) holds
// the input off until its last result moves into the output register.
// Reset (rst_ni low, asynchronous): parser, busy flag, tick counter and remembered
// frame cleared, retry_interval set to 50, report_enable cleared, no results pending.
module touch_link_frame_endpoint (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  sleep_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  value_o,
  output logic        last_o
);

  logic [15:0] ri_q;
  logic        rep_q;

  logic [1:0]  ps_q, ps_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [7:0]  mid_q, mid_d;
  logic        busy_q, busy_d;
  logic [15:0] tw_q, tw_d;
  logic [7:0]  lfm_q, lfm_d;

  logic                           bk_q [tlfe_pkg::MAX_RES];
  logic [7:0]                     bv_q [tlfe_pkg::MAX_RES];
  logic [tlfe_pkg::RES_CW-1:0]    cnt_q;
  logic [tlfe_pkg::RES_IW-1:0]    rd_q;

  logic                           nk [tlfe_pkg::MAX_RES];
  logic [7:0]                     nv [tlfe_pkg::MAX_RES];
  logic [tlfe_pkg::RES_CW-1:0]    nn;

  logic        out_valid_q, out_kind_q, out_last_q;
  logic [7:0]  out_value_q;

  logic        pop, accept;
  logic [15:0] tw_inc;
  logic [7:0]  arg;

  assign pop        = (cnt_q != '0) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((cnt_q == '0) ||
                        ((cnt_q == tlfe_pkg::RES_CW'(1)) && pop));
  assign accept     = in_valid_i && !in_stall_o;

  assign tw_inc = (tw_q == tlfe_pkg::TICKS_MAX) ? tw_q : tw_q + 16'd1;

  always_comb begin
    ps_d   = ps_q;
    hdr_d  = hdr_q;
    mid_d  = mid_q;
    busy_d = busy_q;
    tw_d   = tw_q;
    lfm_d  = lfm_q;
    nn     = '0;
    arg    = tlfe_pkg::CLOSE_ARG;
    for (int i = 0; i < tlfe_pkg::MAX_RES; i++) begin
      nk[i] = tlfe_pkg::KIND_TX;
      nv[i] = '0;
    end
    case (tlfe_pkg::action_e'(action_i))
      tlfe_pkg::ACT_RX: begin
        case (ps_q)
          2'd0: begin
            if (rx_byte_i == tlfe_pkg::HDR_TOUCH || rx_byte_i == tlfe_pkg::HDR_CMD ||
                rx_byte_i == tlfe_pkg::HDR_ACK) begin
              hdr_d = rx_byte_i;
              ps_d  = 2'd1;
            end
          end
          2'd1: begin
            mid_d = rx_byte_i;
            ps_d  = 2'd2;
          end
          2'd2: begin
            ps_d = 2'd0;
            if (rx_byte_i == tlfe_pkg::TAIL_CMD || rx_byte_i == tlfe_pkg::TAIL_LF) begin
              if (hdr_q == tlfe_pkg::HDR_ACK) begin
                if (mid_q == tlfe_pkg::ACK_MID && rx_byte_i == tlfe_pkg::TAIL_LF) begin
                  busy_d = 1'b0;
                  tw_d   = '0;
                end
              end else if (hdr_q == tlfe_pkg::HDR_TOUCH && rep_q) begin
                nk[0] = tlfe_pkg::KIND_REPORT;
                nv[0] = mid_q;
                nv[1] = tlfe_pkg::HDR_ACK;
                nv[2] = tlfe_pkg::ACK_MID;
                nv[3] = tlfe_pkg::TAIL_LF;
                nn    = tlfe_pkg::RES_CW'(4);
              end else if (hdr_q == tlfe_pkg::HDR_TOUCH || hdr_q == tlfe_pkg::HDR_CMD) begin
                nv[0] = tlfe_pkg::HDR_ACK;
                nv[1] = tlfe_pkg::ACK_MID;
                nv[2] = tlfe_pkg::TAIL_LF;
                nn    = tlfe_pkg::RES_CW'(3);
              end
            end
          end
          default: ps_d = 2'd0;
        endcase
      end
      tlfe_pkg::ACT_TICK: begin
        if (!busy_q) begin
          tw_d = '0;
        end else if (tw_inc >= ri_q) begin
          tw_d  = '0;
          nv[0] = tlfe_pkg::HDR_CMD;
          nv[1] = lfm_q;
          nv[2] = tlfe_pkg::TAIL_CMD;
          nn    = tlfe_pkg::RES_CW'(3);
        end else begin
          tw_d = tw_inc;
        end
      end
      default: begin
        if (tlfe_pkg::action_e'(action_i) == tlfe_pkg::ACT_SLEEP) begin
          arg = (sleep_time_i > tlfe_pkg::SLEEP_MAX) ? tlfe_pkg::SLEEP_MAX : sleep_time_i;
        end
        if (!busy_q) begin
          tw_d = '0;
        end
        busy_d = 1'b1;
        lfm_d  = arg;
        nv[0]  = tlfe_pkg::HDR_CMD;
        nv[1]  = arg;
        nv[2]  = tlfe_pkg::TAIL_CMD;
        nn     = tlfe_pkg::RES_CW'(3);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q   <= tlfe_pkg::RETRY_RESET;
      rep_q  <= 1'b0;
      ps_q   <= '0;
      hdr_q  <= '0;
      mid_q  <= '0;
      busy_q <= 1'b0;
      tw_q   <= '0;
      lfm_q  <= '0;
      cnt_q  <= '0;
      rd_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (tlfe_pkg::cfg_index_e'(cfg_index_i))
          tlfe_pkg::CFG_RETRY_INTERVAL: ri_q  <= cfg_data_i;
          tlfe_pkg::CFG_REPORT_ENABLE:  rep_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        ps_q   <= ps_d;
        hdr_q  <= hdr_d;
        mid_q  <= mid_d;
        busy_q <= busy_d;
        tw_q   <= tw_d;
        lfm_q  <= lfm_d;
        cnt_q  <= nn;
        rd_q   <= '0;
      end else if (pop) begin
        cnt_q <= cnt_q - tlfe_pkg::RES_CW'(1);
        rd_q  <= rd_q + tlfe_pkg::RES_IW'(1);
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < tlfe_pkg::MAX_RES; i++) begin
        bk_q[i] <= nk[i];
        bv_q[i] <= nv[i];
      end
    end
    if (pop) begin
      out_kind_q  <= bk_q[rd_q];
      out_value_q <= bv_q[rd_q];
      out_last_q  <= (cnt_q == tlfe_pkg::RES_CW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign value_o     = out_value_q;
  assign last_o      = out_last_q;

endmodule

[rtl/tlfe_checker.sv]
module tlfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  action_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [7:0]  value_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) &&
                                   $stable(kind_o) && $stable(last_o))
    else $error("stalled result changed");

  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (action_i == tlfe_pkg::ACT_SLEEP || action_i == tlfe_pkg::ACT_CLOSE) |=> in_stall_o)
    else $error("command frame did not hold off the input");

  a_report_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == tlfe_pkg::KIND_REPORT |-> !last_o)
    else $error("touch report not followed by its ack");

  a_last_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |->
      value_o == tlfe_pkg::TAIL_LF || value_o == tlfe_pkg::TAIL_CMD)
    else $error("final result is not a frame tail");

endmodule

bind touch_link_frame_endpoint tlfe_checker u_tlfe_checker (.*);
